@@ rtl/peak_to_peak_current_meter_unit_assert.svh @@
// Assertion macros shared by the peak-to-peak current meter RTL.
// Each file that asserts includes this header; the file must have clk and rst_n.
// Defining NO_ASSERTIONS compiles all assertions away.
`ifndef PEAK_TO_PEAK_CURRENT_METER_UNIT_ASSERT_SVH
`define PEAK_TO_PEAK_CURRENT_METER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked only while out of reset.
`define PTP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("peak-to-peak meter assertion failed");

// Checked at every edge, reset included.
`define PTP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("peak-to-peak meter assertion failed");

`else

`define PTP_ASSERT(lbl, prop)
`define PTP_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

@@ rtl/ptp_pkg.sv @@
// Package for the peak-to-peak current meter: configuration struct,
// register indexes, reset values and fixed widths. No dependencies.
package ptp_pkg;

  localparam int CFG_IDX_W       = 4;
  localparam int CFG_DATA_W      = 16;
  localparam int WLEN_W          = 16;
  localparam int FLOOR_W         = 10;
  localparam int GAIN_W          = 16;
  localparam int MA_W            = 16;
  localparam int GAIN_SHIFT      = 10;
  localparam int SAMPLE_BITS_MAX = 16;
  // Wide enough for the shifted product at the largest sample width.
  localparam int MA_EXT_W        = SAMPLE_BITS_MAX + GAIN_W - GAIN_SHIFT;
  // Common width for comparing an amplitude against the noise floor.
  localparam int CMP_W           = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_STEP_MA = 4'd3;

  localparam logic [WLEN_W-1:0]  RST_WINDOW_LENGTH  = 16'd500;
  localparam logic [FLOOR_W-1:0] RST_NOISE_FLOOR    = 10'd18;
  localparam logic [GAIN_W-1:0]  RST_CURRENT_GAIN   = 16'd53019;
  localparam logic [MA_W-1:0]    RST_REPORT_STEP_MA = 16'd500;

  typedef struct packed {
    logic [WLEN_W-1:0]  window_length;
    logic [FLOOR_W-1:0] noise_floor;
    logic [GAIN_W-1:0]  current_gain;
    logic [MA_W-1:0]    report_step_ma;
  } ptp_cfg_t;

endpackage

@@ rtl/ptp_window.sv @@
// Window tracker: running minimum, maximum and sample count, and the
// amplitude register loaded when a window closes. Depends on ptp_pkg and the assertion header.
`include "peak_to_peak_current_meter_unit_assert.svh"

module ptp_window
  import ptp_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ptp_cfg_t               cfg,
  input  logic                   in_valid,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   in_ready,
  output logic                   amp_valid,
  output logic [SAMPLE_BITS-1:0] amp,
  input  logic                   amp_ready
);

  logic [SAMPLE_BITS-1:0] low_r, low_nxt;
  logic [SAMPLE_BITS-1:0] high_r, high_nxt;
  logic [WLEN_W-1:0]      count_r, count_nxt;
  logic [WLEN_W-1:0]      len;
  logic [SAMPLE_BITS-1:0] amp_raw;
  logic [SAMPLE_BITS-1:0] amp_nxt;
  logic [SAMPLE_BITS-1:0] amp_r;
  logic                   amp_valid_r;
  logic                   accept;
  logic                   close;

  assign in_ready  = !amp_valid_r || amp_ready;
  assign accept    = in_valid && in_ready;
  assign amp_valid = amp_valid_r;
  assign amp       = amp_r;

  always_comb begin
    len       = (cfg.window_length == '0) ? WLEN_W'(1) : cfg.window_length;
    count_nxt = count_r + WLEN_W'(1);
    // A count that wrapped to zero also closes the window.
    close     = (count_nxt == '0) || (count_nxt >= len);
    low_nxt   = (in_sample < low_r)  ? in_sample : low_r;
    high_nxt  = (in_sample > high_r) ? in_sample : high_r;
    amp_raw   = (high_nxt >= low_nxt) ? (high_nxt - low_nxt) : '0;
    amp_nxt   = (CMP_W'(amp_raw) < CMP_W'(cfg.noise_floor)) ? '0 : amp_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r       <= '1;
      high_r      <= '0;
      count_r     <= '0;
      amp_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        if (close) begin
          low_r   <= '1;
          high_r  <= '0;
          count_r <= '0;
        end else begin
          low_r   <= low_nxt;
          high_r  <= high_nxt;
          count_r <= count_nxt;
        end
      end
      if (in_ready) begin
        amp_valid_r <= accept && close;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && close) begin
      amp_r <= amp_nxt;
    end
  end

  `PTP_ASSERT(a_close_restarts, (accept && close) |=> (count_r == '0 && high_r == '0))
  `PTP_ASSERT(a_low_below_high, (count_r != '0) |-> (low_r <= high_r))
  `PTP_ASSERT(a_amp_after_close, $rose(amp_valid_r) |-> $past(accept && close))

endmodule

@@ rtl/ptp_scale.sv @@
// Scaling stage: amplitude times gain, shifted down and saturated to
// milliamps, held in a stage register. Depends on ptp_pkg.
module ptp_scale
  import ptp_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ptp_cfg_t               cfg,
  input  logic                   amp_valid,
  input  logic [SAMPLE_BITS-1:0] amp,
  output logic                   amp_ready,
  output logic                   ma_valid,
  output logic [SAMPLE_BITS-1:0] ma_amp,
  output logic [MA_W-1:0]        ma,
  input  logic                   ma_ready
);

  localparam int PROD_W = SAMPLE_BITS + GAIN_W;

  logic [PROD_W-1:0]          prod;
  logic [PROD_W-GAIN_SHIFT-1:0] ma_full;
  logic [MA_EXT_W-1:0]        ma_ext;
  logic [MA_W-1:0]            ma_sat;
  logic                       valid_r;
  logic [SAMPLE_BITS-1:0]     amp_r;
  logic [MA_W-1:0]            ma_r;

  assign amp_ready = !valid_r || ma_ready;
  assign ma_valid  = valid_r;
  assign ma_amp    = amp_r;
  assign ma        = ma_r;

  always_comb begin
    prod    = PROD_W'(amp) * PROD_W'(cfg.current_gain);
    ma_full = prod[PROD_W-1:GAIN_SHIFT];
    ma_ext  = MA_EXT_W'(ma_full);
    // Only wide samples can push the result past sixteen bits.
    ma_sat  = (|ma_ext[MA_EXT_W-1:MA_W]) ? '1 : ma_ext[MA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (amp_ready) begin
      valid_r <= amp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (amp_ready && amp_valid) begin
      amp_r <= amp;
      ma_r  <= ma_sat;
    end
  end

endmodule

@@ rtl/ptp_report.sv @@
// Report stage: compares the current with the last reported value, keeps
// that value, and holds the result register. Depends on ptp_pkg and the assertion header.
`include "peak_to_peak_current_meter_unit_assert.svh"

module ptp_report
  import ptp_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ptp_cfg_t               cfg,
  input  logic                   ma_valid,
  input  logic [SAMPLE_BITS-1:0] ma_amp,
  input  logic [MA_W-1:0]        ma,
  output logic                   ma_ready,
  output logic                   out_valid,
  output logic [SAMPLE_BITS-1:0] out_amplitude,
  output logic [MA_W-1:0]        out_current_ma,
  output logic                   out_changed,
  input  logic                   out_ready
);

  logic [MA_W-1:0]        last_r;
  logic [MA_W-1:0]        diff;
  logic                   chg;
  logic                   load;
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] amp_r;
  logic [MA_W-1:0]        cur_r;
  logic                   chg_r;

  assign ma_ready       = !out_valid_r || out_ready;
  assign load           = ma_valid && ma_ready;
  assign out_valid      = out_valid_r;
  assign out_amplitude  = amp_r;
  assign out_current_ma = cur_r;
  assign out_changed    = chg_r;

  always_comb begin
    diff = (ma >= last_r) ? (ma - last_r) : (last_r - ma);
    chg  = diff > cfg.report_step_ma;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_r      <= '0;
    end else begin
      if (ma_ready) begin
        out_valid_r <= ma_valid;
      end
      if (load && chg) begin
        last_r <= ma;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      amp_r <= ma_amp;
      cur_r <= ma;
      chg_r <= chg;
    end
  end

  `PTP_ASSERT(a_last_follows_change, (load && chg) |=> (last_r == cur_r && chg_r))
  `PTP_ASSERT(a_last_kept, (load && !chg) |=> $stable(last_r))
  `PTP_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid_r)

endmodule

@@ rtl/peak_to_peak_current_meter_unit.sv @@
// Top level of the peak-to-peak current meter: configuration registers and
// the three pipeline stages. Depends on ptp_pkg, ptp_window, ptp_scale, ptp_report.
//
// Usage:
//   in_valid/in_ready/in_sample carry one converter sample per transfer.
//   out_valid/out_ready carry one result per closed window: out_amplitude,
//   out_current_ma and out_changed. Samples that do not close a window give
//   no result.
//   cfg_valid/cfg_ready/cfg_index/cfg_wdata write the window length (0),
//   noise floor (1), current gain (2) and report step (3); other indexes are
//   ignored. cfg_ready is always high. Write only while the block is idle.
// Timing:
//   One sample is taken every cycle while in_ready is high. The result of the
//   sample that closes a window passes the amplitude register, the multiplier
//   stage register and the result register on its way to the outputs.
//   When the receiver stalls, results back up in those registers; in_ready
//   drops only once all three are full and the output is not taken.
// Reset:
//   Registers return to their defaults (500, 18, 53019, 500), a new window
//   opens, the last reported current becomes zero and the pipeline empties.
module peak_to_peak_current_meter_unit
  import ptp_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_amplitude,
  output logic [MA_W-1:0]        out_current_ma,
  output logic                   out_changed,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  ptp_cfg_t               cfg_r;
  logic                   amp_valid;
  logic [SAMPLE_BITS-1:0] amp;
  logic                   amp_ready;
  logic                   ma_valid;
  logic [SAMPLE_BITS-1:0] ma_amp;
  logic [MA_W-1:0]        ma;
  logic                   ma_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_length  <= RST_WINDOW_LENGTH;
      cfg_r.noise_floor    <= RST_NOISE_FLOOR;
      cfg_r.current_gain   <= RST_CURRENT_GAIN;
      cfg_r.report_step_ma <= RST_REPORT_STEP_MA;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_LENGTH:  cfg_r.window_length  <= cfg_wdata[WLEN_W-1:0];
        REG_NOISE_FLOOR:    cfg_r.noise_floor    <= cfg_wdata[FLOOR_W-1:0];
        REG_CURRENT_GAIN:   cfg_r.current_gain   <= cfg_wdata[GAIN_W-1:0];
        REG_REPORT_STEP_MA: cfg_r.report_step_ma <= cfg_wdata[MA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ptp_window #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_sample (in_sample),
    .in_ready  (in_ready),
    .amp_valid (amp_valid),
    .amp       (amp),
    .amp_ready (amp_ready)
  );

  ptp_scale #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .amp_valid (amp_valid),
    .amp       (amp),
    .amp_ready (amp_ready),
    .ma_valid  (ma_valid),
    .ma_amp    (ma_amp),
    .ma        (ma),
    .ma_ready  (ma_ready)
  );

  ptp_report #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_report (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .ma_valid       (ma_valid),
    .ma_amp         (ma_amp),
    .ma             (ma),
    .ma_ready       (ma_ready),
    .out_valid      (out_valid),
    .out_amplitude  (out_amplitude),
    .out_current_ma (out_current_ma),
    .out_changed    (out_changed),
    .out_ready      (out_ready)
  );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for peak_to_peak_current_meter_unit: samples go in over valid/ready,
// window results come back and are compared against an in-bench window predictor.
// Depends on ptp_pkg and the meter RTL.
module testbench;
  import ptp_pkg::*;

  localparam int SB           = 10;
  localparam int DRAIN_CYCLES = 6;
  localparam int QUIET_LIMIT  = 2000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [SB-1:0]   amplitude;
    logic [MA_W-1:0] current_ma;
    logic            changed;
  } meter_reading_t;

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [SB-1:0]         in_sample      = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [SB-1:0]         out_amplitude;
  logic [MA_W-1:0]       out_current_ma;
  logic                  out_changed;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata      = '0;

  // Predictor copy of the configuration and window state.
  logic [WLEN_W-1:0]  win_length  = RST_WINDOW_LENGTH;
  logic [FLOOR_W-1:0] noise_limit = RST_NOISE_FLOOR;
  logic [GAIN_W-1:0]  gain_q10    = RST_CURRENT_GAIN;
  logic [MA_W-1:0]    step_ma     = RST_REPORT_STEP_MA;
  logic [SB-1:0]      win_low     = '1;
  logic [SB-1:0]      win_high    = '0;
  logic [WLEN_W-1:0]  win_count   = '0;
  logic [MA_W-1:0]    reported_ma = '0;

  meter_reading_t pending_readings[$];
  meter_reading_t due;

  bit steady = 1'b0;
  int mismatches    = 0;
  int samples_sent  = 0;
  int windows_seen  = 0;
  int random_phases = 0;
  int quiet_cycles  = 0;

  peak_to_peak_current_meter_unit #(.SAMPLE_BITS(SB)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_amplitude  (out_amplitude),
    .out_current_ma (out_current_ma),
    .out_changed    (out_changed),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Fold one accepted sample into the window and queue the reading it closes, if any.
  task automatic absorb_sample(input logic [SB-1:0] value);
    logic [WLEN_W-1:0]         span;
    logic [SB-1:0]             amp;
    logic [SB+GAIN_W-1:0]      product;
    logic [SB+GAIN_W-1:0]      scaled;
    logic [MA_W-1:0]           ma;
    logic [MA_W-1:0]           diff;
    meter_reading_t            reading;
    if (value < win_low) win_low = value;
    if (value > win_high) win_high = value;
    win_count = win_count + 1'b1;
    span = (win_length == '0) ? WLEN_W'(1) : win_length;
    if (win_count < span && win_count != '0) return;
    amp = (win_high >= win_low) ? win_high - win_low : '0;
    if ({6'd0, amp} < {6'd0, noise_limit}) amp = '0;
    product = amp * gain_q10;
    scaled = product >> GAIN_SHIFT;
    ma = (scaled > (SB+GAIN_W)'(16'hFFFF)) ? 16'hFFFF : scaled[MA_W-1:0];
    diff = (ma >= reported_ma) ? ma - reported_ma : reported_ma - ma;
    reading.amplitude  = amp;
    reading.current_ma = ma;
    reading.changed    = diff > step_ma;
    if (reading.changed) reported_ma = ma;
    pending_readings.push_back(reading);
    win_low   = '1;
    win_high  = '0;
    win_count = '0;
  endtask

  task automatic send_sample(input logic [SB-1:0] value);
    // A finished register write is released by the first sample after it.
    cfg_valid <= 1'b0;
    while (!steady && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_sample(value);
    samples_sent++;
  endtask

  // Leaves cfg_valid high so that writes can follow back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_WINDOW_LENGTH:  win_length  = data;
      REG_NOISE_FLOOR:    noise_limit = data[FLOOR_W-1:0];
      REG_CURRENT_GAIN:   gain_q10    = data;
      REG_REPORT_STEP_MA: step_ma     = data;
      default: ;
    endcase
  endtask

  // Wait until every queued reading has come out, then give a sample that
  // closed no window time to leave the pipeline.
  task automatic settle();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SB-1:0] near(input int base, input int spread);
    int v;
    v = base + int'($urandom_range(spread)) - spread / 2;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return SB'(v);
  endfunction

  // Reset defaults, then a window length lowered below the samples already taken.
  task automatic test_lowered_window();
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd512);
    settle();
    write_reg(REG_WINDOW_LENGTH, 16'd2);
    send_sample(10'd700);
  endtask

  // A zero length acts as one: every sample closes a window.
  task automatic test_zero_window();
    settle();
    write_reg(REG_WINDOW_LENGTH, 16'd0);
    send_sample(10'd1023);
    send_sample(10'd0);
    send_sample(10'd0);
    send_sample(10'd1023);
  endtask

  task automatic test_noise_floor();
    settle();
    write_reg(REG_WINDOW_LENGTH, 16'd2);
    write_reg(REG_NOISE_FLOOR, 16'd1023);
    send_sample(10'd0);
    send_sample(10'd1022);
    send_sample(10'd0);
    send_sample(10'd1023);
    settle();
    write_reg(REG_NOISE_FLOOR, 16'd0);
    send_sample(10'd7);
    send_sample(10'd7);
  endtask

  task automatic test_gain_and_step();
    settle();
    write_reg(REG_CURRENT_GAIN, 16'hFFFF);
    write_reg(REG_REPORT_STEP_MA, 16'hFFFF);
    send_sample(10'd0);
    send_sample(10'd1023);
    settle();
    write_reg(REG_CURRENT_GAIN, 16'd0);
    write_reg(REG_REPORT_STEP_MA, 16'd0);
    send_sample(10'd1023);
    send_sample(10'd0);
  endtask

  // Bits above the floor's width and writes to unused indexes must be ignored.
  task automatic test_register_width();
    settle();
    write_reg(REG_CURRENT_GAIN, RST_CURRENT_GAIN);
    write_reg(REG_NOISE_FLOOR, 16'hFC05);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0000);
    send_sample(10'd10);
    send_sample(10'd14);
    send_sample(10'd10);
    send_sample(10'd15);
  endtask

  task automatic test_longest_window();
    settle();
    write_reg(REG_WINDOW_LENGTH, 16'hFFFF);
    send_sample(10'd300);
    send_sample(10'd1);
    send_sample(10'd900);
    settle();
    write_reg(REG_WINDOW_LENGTH, 16'd1);
    send_sample(10'd1000);
  endtask

  // Short windows with neither side ever stalling.
  task automatic test_back_to_back();
    settle();
    steady = 1'b1;
    write_reg(REG_WINDOW_LENGTH, 16'($urandom_range(1, 3)));
    write_reg(REG_NOISE_FLOOR, 16'($urandom_range(0, 40)));
    write_reg(REG_REPORT_STEP_MA, 16'($urandom_range(0, 2000)));
    for (int i = 0; i < 120; i++) send_sample(SB'($urandom_range(1023)));
    settle();
    steady = 1'b0;
  endtask

  task automatic test_random_windows();
    int wl;
    int per_window;
    int count;
    int base;
    int spread;
    logic [GAIN_W-1:0] gain;
    logic [MA_W-1:0]   step;
    while (samples_sent < 1000 || windows_seen < 60) begin
      settle();
      case ($urandom_range(9))
        0: wl = 0;
        1: wl = 1;
        8: wl = $urandom_range(13, 64);
        9: wl = $urandom_range(65, 200);
        default: wl = $urandom_range(2, 12);
      endcase
      case ($urandom_range(4))
        0: gain = '0;
        1: gain = '1;
        2: gain = RST_CURRENT_GAIN;
        default: gain = GAIN_W'($urandom);
      endcase
      case ($urandom_range(4))
        0: step = '0;
        1: step = '1;
        default: step = MA_W'($urandom_range(0, 3000));
      endcase
      write_reg(REG_WINDOW_LENGTH, 16'(wl));
      if ($urandom_range(3) == 0)
        write_reg(REG_NOISE_FLOOR, {6'($urandom), 10'($urandom_range(1023))});
      else
        write_reg(REG_NOISE_FLOOR, {6'($urandom), 10'($urandom_range(60))});
      write_reg(REG_CURRENT_GAIN, gain);
      write_reg(REG_REPORT_STEP_MA, step);
      if ($urandom_range(3) == 0)
        write_reg(REG_SPARE_LO + CFG_IDX_W'($urandom_range(11)), 16'($urandom));
      per_window = (wl > 1) ? wl : 1;
      count = $urandom_range(per_window, 3 * per_window);
      for (int i = 0; i < count; i++) begin
        if (i % per_window == 0) begin
          base = $urandom_range(1023);
          case ($urandom_range(2))
            0: spread = $urandom_range(4);
            1: spread = $urandom_range(80);
            default: spread = 1023;
          endcase
        end
        if ($urandom_range(9) == 0)
          send_sample(SB'($urandom_range(1023)));
        else
          send_sample(near(base, spread));
      end
      random_phases++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: reading with none expected: amplitude %0d, current %0d, changed %0d",
                 $time, out_amplitude, out_current_ma, out_changed);
        mismatches++;
      end else begin
        due = pending_readings.pop_front();
        windows_seen++;
        if (out_amplitude !== due.amplitude) begin
          $display("%0t: amplitude expected %0d, got %0d", $time, due.amplitude, out_amplitude);
          mismatches++;
        end
        if (out_current_ma !== due.current_ma) begin
          $display("%0t: current_ma expected %0d, got %0d",
                   $time, due.current_ma, out_current_ma);
          mismatches++;
        end
        if (out_changed !== due.changed) begin
          $display("%0t: changed expected %0d, got %0d", $time, due.changed, out_changed);
          mismatches++;
        end
      end
    end
    out_ready <= steady || ($urandom_range(99) >= 15);
  end

  // Ends the run when no transfer happens on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_lowered_window();
    test_zero_window();
    test_noise_floor();
    test_gain_and_step();
    test_register_width();
    test_longest_window();
    test_back_to_back();
    test_random_windows();
    settle();
    $display("Covered %0d samples and %0d closed windows, %0d random register settings.",
             samples_sent, windows_seen, random_phases);
    $display("Mismatches found: %0d", mismatches);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ peak_to_peak_current_meter_unit.f @@
+incdir+rtl
rtl/ptp_pkg.sv
rtl/ptp_window.sv
rtl/ptp_scale.sv
rtl/ptp_report.sv
rtl/peak_to_peak_current_meter_unit.sv
bench/testbench.sv
